[rtl/qrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types, widths and helper functions for the quaternion to rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // Input component width and output fraction bits
  localparam int W  = 16;
  localparam int F  = 14;
  localparam int OW = F + 2;
  // Product width and numerator / norm width
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 2;
  // Quotient bits produced by the divider, one per stage
  localparam int QB = F + 2;
  // Matrix entries
  localparam int NE = 9;

  typedef struct packed {
    logic signed [W-1:0] quat_w;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OW-1:0] m00;
    logic signed [OW-1:0] m01;
    logic signed [OW-1:0] m02;
    logic signed [OW-1:0] m10;
    logic signed [OW-1:0] m11;
    logic signed [OW-1:0] m12;
    logic signed [OW-1:0] m20;
    logic signed [OW-1:0] m21;
    logic signed [OW-1:0] m22;
    logic                 zero_input;
  } result_t;

  // Sign and magnitude of one entry's numerator
  typedef struct packed {
    logic          neg;
    logic [NW-1:0] mag;
  } num_t;

  // Diagonal numerator: difference of two sums of squares
  function automatic num_t diag_num(input logic [NW-1:0] pos, input logic [NW-1:0] negp);
    num_t r;
    r.neg = pos < negp;
    r.mag = r.neg ? (negp - pos) : (pos - negp);
    return r;
  endfunction

  // Off-diagonal numerator: 2 * (p1 +/- p2)
  function automatic num_t off_num(input logic signed [PW-1:0] p1,
                                   input logic signed [PW-1:0] p2,
                                   input logic                 sub);
    logic signed [NW-1:0] a;
    logic signed [NW-1:0] b;
    logic signed [NW-1:0] s;
    logic [NW-1:0]        m;
    num_t                 r;
    a = {{2{p1[PW-1]}}, p1};
    b = {{2{p2[PW-1]}}, p2};
    s = sub ? (a - b) : (a + b);
    r.neg = s[NW-1];
    m = r.neg ? NW'(-s) : NW'(s);
    r.mag = {m[NW-2:0], 1'b0};
    return r;
  endfunction

endpackage

[rtl/quaternion_to_rotation_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts one quaternion per cycle into a normalised 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion may be started every cycle (busy is always
// low) and its matrix appears on result with a one-cycle done strobe after a
// product stage, a numerator stage, the divider, which resolves one quotient
// bit per stage for all nine entries in parallel, and a rounding stage. The
// receiver cannot stall; every result must be taken in the cycle done is high.
// An all-zero quaternion gives the identity with zero_input set.
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  quat_t   quat,
  output logic    done,
  output result_t result
);

  localparam int LAT = QB + 3;
  localparam logic [QB-1:0] ONE = QB'(1) << F;

  assign busy = 1'b0;

  // Components sign-extended to product width
  logic signed [PW-1:0] qw, qx, qy, qz;

  assign qw = {{(PW-W){quat.quat_w[W-1]}}, quat.quat_w};
  assign qx = {{(PW-W){quat.quat_x[W-1]}}, quat.quat_x};
  assign qy = {{(PW-W){quat.quat_y[W-1]}}, quat.quat_y};
  assign qz = {{(PW-W){quat.quat_z[W-1]}}, quat.quat_z};

  // Stage 1: squares and cross products
  logic                 v1;
  logic                 z1;
  logic [PW-1:0]        ww, xx, yy, zz;
  logic signed [PW-1:0] xy, zw, xz, yw, yz, xw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    z1 <= (quat.quat_w == '0) && (quat.quat_x == '0) &&
          (quat.quat_y == '0) && (quat.quat_z == '0);
    ww <= qw * qw;
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    xy <= qx * qy;
    zw <= qz * qw;
    xz <= qx * qz;
    yw <= qy * qw;
    yz <= qy * qz;
    xw <= qx * qw;
  end

  // Stage 2 numerators and norm
  num_t          num_c [NE];
  logic [NW-1:0] n_c;

  always_comb begin
    n_c      = NW'(ww) + NW'(xx) + NW'(yy) + NW'(zz);
    num_c[0] = diag_num(NW'(ww) + NW'(xx), NW'(yy) + NW'(zz));
    num_c[1] = off_num(xy, zw, 1'b1);
    num_c[2] = off_num(xz, yw, 1'b0);
    num_c[3] = off_num(xy, zw, 1'b0);
    num_c[4] = diag_num(NW'(ww) + NW'(yy), NW'(xx) + NW'(zz));
    num_c[5] = off_num(yz, xw, 1'b1);
    num_c[6] = off_num(xz, yw, 1'b1);
    num_c[7] = off_num(yz, xw, 1'b0);
    num_c[8] = diag_num(NW'(ww) + NW'(zz), NW'(xx) + NW'(yy));
  end

  // Divider pipeline: index 0 holds the numerators, stage s+1 one more bit
  logic          dv   [QB+1];
  logic          dz   [QB+1];
  logic [NW-1:0] dn   [QB+1];
  logic [NW:0]   drem [QB+1][NE];
  logic [QB-1:0] dq   [QB+1][NE];
  logic          dneg [QB+1][NE];

  logic [NW:0]   nrem [QB][NE];
  logic [QB-1:0] nq   [QB][NE];

  // Restoring step, shift skipped on the leading bit
  always_comb begin
    logic [NW:0] r_sh;
    logic        ge;
    for (int s = 0; s < QB; s++) begin
      for (int e = 0; e < NE; e++) begin
        r_sh = (s == 0) ? drem[s][e] : {drem[s][e][NW-1:0], 1'b0};
        ge   = r_sh >= {1'b0, dn[s]};
        nrem[s][e] = ge ? (r_sh - {1'b0, dn[s]}) : r_sh;
        nq[s][e]   = {dq[s][e][QB-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QB; s++) dv[s] <= 1'b0;
    end else begin
      dv[0] <= v1;
      for (int s = 0; s < QB; s++) dv[s+1] <= dv[s];
    end
    dz[0] <= z1;
    dn[0] <= n_c;
    for (int e = 0; e < NE; e++) begin
      drem[0][e] <= {1'b0, num_c[e].mag};
      dq[0][e]   <= '0;
      dneg[0][e] <= num_c[e].neg;
    end
    for (int s = 0; s < QB; s++) begin
      dz[s+1] <= dz[s];
      dn[s+1] <= dn[s];
      for (int e = 0; e < NE; e++) begin
        drem[s+1][e] <= nrem[s][e];
        dq[s+1][e]   <= nq[s][e];
        dneg[s+1][e] <= dneg[s][e];
      end
    end
  end

  // Round half away from zero, clamp, apply sign
  logic signed [OW-1:0] mv [NE];

  always_comb begin
    logic [QB:0]   rs;
    logic [QB-1:0] r;
    for (int e = 0; e < NE; e++) begin
      rs = {1'b0, dq[QB][e]} + (QB+1)'(1);
      r  = rs[QB:1];
      if (r > ONE) r = ONE;
      if (dz[QB]) begin
        mv[e] = (e == 0 || e == 4 || e == 8) ? OW'(ONE) : '0;
      end else begin
        mv[e] = dneg[QB][e] ? -OW'(r) : OW'(r);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QB];
    end
    result.m00        <= mv[0];
    result.m01        <= mv[1];
    result.m02        <= mv[2];
    result.m10        <= mv[3];
    result.m11        <= mv[4];
    result.m12        <= mv[5];
    result.m20        <= mv[6];
    result.m21        <= mv[7];
    result.m22        <= mv[8];
    result.zero_input <= dz[QB];
  end

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("result strobe missing after start");

  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    (start && quat.quat_w == '0 && quat.quat_x == '0 &&
     quat.quat_y == '0 && quat.quat_z == '0) |-> ##LAT (done && result.zero_input))
    else $error("zero quaternion not flagged");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m00 <= $signed(OW'(ONE)) && result.m00 >= -$signed(OW'(ONE)) &&
              result.m11 <= $signed(OW'(ONE)) && result.m11 >= -$signed(OW'(ONE))))
    else $error("diagonal entry out of range");

endmodule
